/* rtl/wmi_pkg.sv */
// ============================================================================
// wmi_pkg
// Shared constants, types and helpers of the wavetable morph interpolator.
// ============================================================================
package wmi_pkg;

    localparam int WAVE_ADDR_BITS = 8;
    localparam int WAVE_NUM_BITS  = 6;
    localparam int STORE_ADDR_W   = WAVE_ADDR_BITS + WAVE_NUM_BITS;
    localparam int STORE_DEPTH    = 1 << STORE_ADDR_W;
    localparam int SAMPLE_W       = 16;
    localparam int FRAC_W         = 16;

    localparam logic [13:0] SCALE_1D = 14'h3eff;
    localparam logic [10:0] SCALE_2D = 11'h700;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 16'hFFFF;

    localparam logic [2:0] LAST_K_1D = 3'd3;
    localparam logic [2:0] LAST_K_2D = 3'd7;

    localparam logic [1:0] CFG_TWO_D   = 2'd0;
    localparam logic [1:0] CFG_MORPH_X = 2'd1;
    localparam logic [1:0] CFG_MORPH_Y = 2'd2;

    typedef struct packed {
        logic [2:0]        k;
        logic              last;
        logic              two_d;
        logic [FRAC_W-1:0] f;
        logic [FRAC_W-1:0] b;
        logic [FRAC_W-1:0] cy;
    } t_tag;

    typedef struct packed {
        logic                    vld;
        logic [STORE_ADDR_W-1:0] addr;
        t_tag                    tag;
    } t_rdreq;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [18:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/wmi_ram.sv */
// ============================================================================
// wmi_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module wmi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/wmi_seq.sv */
// ============================================================================
// wmi_seq
// Read sequencer: takes sample requests, scales the morph position and issues
// the four or eight wave reads of each request.
// ============================================================================
module wmi_seq import wmi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_func,
    input  logic [31:0]         i_phase,
    input  logic                i_two_d,
    input  logic [15:0]         i_morph_x,
    input  logic [15:0]         i_morph_y,
    input  logic                i_room,
    output logic                o_in_ready,
    output t_rdreq              o_rd
);

    logic                     r_busy;
    logic [2:0]               r_k;
    logic                     r_two_d;
    logic [WAVE_NUM_BITS-1:0] r_wa;
    logic [WAVE_ADDR_BITS-1:0] r_i0;
    logic [FRAC_W-1:0]        r_f;
    logic [FRAC_W-1:0]        r_b;
    logic [FRAC_W-1:0]        r_cy;

    logic                     w_last;
    logic                     w_take;
    logic [29:0]              w_px1;
    logic [26:0]              w_px2;
    logic [26:0]              w_py2;
    logic [WAVE_NUM_BITS-1:0] n_wa;
    logic [FRAC_W-1:0]        n_b;
    logic [FRAC_W-1:0]        n_cy;
    logic [WAVE_NUM_BITS-1:0] w_wave;
    logic [WAVE_ADDR_BITS-1:0] w_idx;

    assign w_last     = r_busy && (r_k == (r_two_d ? LAST_K_2D : LAST_K_1D));
    assign o_in_ready = (!r_busy || w_last) && i_room;
    assign w_take     = i_in_valid && o_in_ready && i_func;

    assign w_px1 = {14'd0, i_morph_x} * {16'd0, SCALE_1D};
    assign w_px2 = {11'd0, i_morph_x} * {16'd0, SCALE_2D};
    assign w_py2 = {11'd0, i_morph_y} * {16'd0, SCALE_2D};

    always_comb begin
        if (i_two_d) begin
            n_wa = {w_py2[26:24], w_px2[26:24]};
            n_b  = w_px2[23:8];
            n_cy = w_py2[23:8];
        end else begin
            n_wa = w_px1[29:24];
            n_b  = w_px1[23:8];
            n_cy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (w_take) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (w_last) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_k <= r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_two_d <= i_two_d;
            r_wa    <= n_wa;
            r_i0    <= i_phase[31:24];
            r_f     <= i_phase[23:8];
            r_b     <= n_b;
            r_cy    <= n_cy;
        end
    end

    assign w_wave = r_wa + {2'b00, r_k[2], 2'b00, r_k[1]};
    assign w_idx  = r_i0 + {7'd0, r_k[0]};

    always_comb begin
        o_rd.vld       = r_busy;
        o_rd.addr      = {w_wave, w_idx};
        o_rd.tag.k     = r_k;
        o_rd.tag.last  = w_last;
        o_rd.tag.two_d = r_two_d;
        o_rd.tag.f     = r_f;
        o_rd.tag.b     = r_b;
        o_rd.tag.cy    = r_cy;
    end

endmodule

/* rtl/wmi_mix.sv */
// ============================================================================
// wmi_mix
// Arithmetic pipeline: phase interpolation, X crossfade, Y crossfade (2D only)
// and saturation over the stream of wave samples read back from the bank.
// ============================================================================
module wmi_mix import wmi_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_rdreq                     i_rd,
    input  logic signed [SAMPLE_W-1:0] i_rdata,
    output logic                       o_res_vld,
    output logic signed [SAMPLE_W-1:0] o_res
);

    logic               r_v0;
    t_tag               r_t0;
    logic               r_va;
    t_tag               r_ta;
    logic signed [32:0] r_pa;
    logic signed [32:0] r_acc1;
    logic               r_vb;
    t_tag               r_tb;
    logic signed [31:0] r_pv;
    logic               r_vc;
    t_tag               r_tc;
    logic signed [48:0] r_pc;
    logic signed [48:0] r_acc2;
    logic               r_vd;
    t_tag               r_td;
    logic signed [16:0] r_row;
    logic               r_ve;
    t_tag               r_te;
    logic signed [33:0] r_pe;
    logic signed [16:0] r_rowe;
    logic signed [33:0] r_acc3;
    logic               r_res_vld;
    logic signed [SAMPLE_W-1:0] r_res;

    logic [FRAC_W-1:0]  w_wa;
    logic [FRAC_W-1:0]  w_wc;
    logic [FRAC_W-1:0]  w_we;
    logic signed [32:0] w_pa;
    logic signed [33:0] w_sv;
    logic signed [48:0] w_pc;
    logic signed [49:0] w_sr;
    logic signed [33:0] w_pe;
    logic signed [34:0] w_sy;

    assign w_wa = r_t0.k[0] ? r_t0.f  : FRAC_MAX - r_t0.f;
    assign w_wc = r_tb.k[1] ? r_tb.b  : FRAC_MAX - r_tb.b;
    assign w_we = r_td.k[2] ? r_td.cy : FRAC_MAX - r_td.cy;

    assign w_pa = i_rdata * $signed({1'b0, w_wa});
    assign w_sv = r_acc1 + r_pa;
    assign w_pc = r_pv * $signed({1'b0, w_wc});
    assign w_sr = r_acc2 + r_pc;
    assign w_pe = r_row * $signed({1'b0, w_we});
    assign w_sy = r_acc3 + r_pe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_va      <= 1'b0;
            r_vb      <= 1'b0;
            r_vc      <= 1'b0;
            r_vd      <= 1'b0;
            r_ve      <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_v0      <= i_rd.vld;
            r_va      <= r_v0;
            r_vb      <= r_va && r_ta.k[0];
            r_vc      <= r_vb;
            r_vd      <= r_vc && r_tc.k[1];
            r_ve      <= r_vd;
            r_res_vld <= r_ve && (!r_te.two_d || r_te.k[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0 <= i_rd.tag;
        r_ta <= r_t0;
        r_pa <= w_pa;
        if (r_va && !r_ta.k[0]) begin
            r_acc1 <= r_pa;
        end
        r_tb <= r_ta;
        r_pv <= w_sv[31:0];
        r_tc <= r_tb;
        r_pc <= w_pc;
        if (r_vc && !r_tc.k[1]) begin
            r_acc2 <= r_pc;
        end
        r_td  <= r_tc;
        r_row <= w_sr[48:32];
        r_te  <= r_td;
        r_pe  <= w_pe;
        r_rowe <= r_row;
        if (r_ve && !r_te.k[2]) begin
            r_acc3 <= r_pe;
        end
        if (r_te.two_d) begin
            r_res <= sat16(w_sy[34:16]);
        end else begin
            r_res <= sat16({{2{r_rowe[16]}}, r_rowe});
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

endmodule

/* rtl/wavetable_morph_interpolator.sv */
// ============================================================================
// wavetable_morph_interpolator
// Wavetable oscillator with phase interpolation and 1D or 2D wave morphing.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request. With i_func
//   low the request writes i_bank_data into bank entry i_bank_address and
//   gives no result. With i_func high it asks for one sample at i_phase.
//   Output channel (o_out_valid / i_out_ready) returns o_sample_out.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   two_dimensional, morph_x and morph_y by index; write it only when idle.
// Throughput: one bank read per cycle, 4 per sample in 1D and 8 in 2D; at
//   most two samples are in flight, so new sample requests wait for a slot.
// Reset: config registers clear; the wave bank is not cleared and holds
//   garbage until written. No clearing pass, the block is ready at once.
// Stall: results wait in a two-entry output queue; at most two sample
//   requests are in flight, so a stalled receiver stops new requests only
//   once both slots are claimed.
// ============================================================================
module wavetable_morph_interpolator import wmi_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_func,
    input  logic [STORE_ADDR_W-1:0]    i_bank_address,
    input  logic signed [SAMPLE_W-1:0] i_bank_data,
    input  logic [31:0]                i_phase,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data
);

    logic        r_two_d;
    logic [15:0] r_morph_x;
    logic [15:0] r_morph_y;
    logic [1:0]  r_inflight;
    logic [1:0]  r_cnt;
    logic signed [SAMPLE_W-1:0] r_q0;
    logic signed [SAMPLE_W-1:0] r_q1;

    t_rdreq                     w_rd;
    logic signed [SAMPLE_W-1:0] w_rdata;
    logic                       w_res_vld;
    logic signed [SAMPLE_W-1:0] w_res;
    logic                       w_room;
    logic                       w_in_acc;
    logic                       w_take;
    logic                       w_pop;
    logic                       w_we;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_d   <= 1'b0;
            r_morph_x <= '0;
            r_morph_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TWO_D:   r_two_d   <= i_cfg_data[0];
                CFG_MORPH_X: r_morph_x <= i_cfg_data;
                CFG_MORPH_Y: r_morph_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_room   = (r_inflight != 2'd2);
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_take   = w_in_acc && i_func;
    assign w_we     = w_in_acc && !i_func;
    assign w_pop    = o_out_valid && i_out_ready;

    wmi_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_phase    (i_phase),
        .i_two_d    (r_two_d),
        .i_morph_x  (r_morph_x),
        .i_morph_y  (r_morph_y),
        .i_room     (w_room),
        .o_in_ready (o_in_ready),
        .o_rd       (w_rd)
    );

    wmi_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_bank_address),
        .i_wdata (i_bank_data),
        .i_re    (w_rd.vld),
        .i_raddr (w_rd.addr),
        .o_rdata (w_rdata)
    );

    wmi_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (w_rd),
        .i_rdata   (w_rdata),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_take && !w_pop) begin
            r_inflight <= r_inflight + 2'd1;
        end else if (w_pop && !w_take) begin
            r_inflight <= r_inflight - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_res_vld && !w_pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (w_pop && !w_res_vld) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (w_res_vld && !w_pop) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_res;
            end else begin
                r_q1 <= w_res;
            end
        end else if (w_pop && !w_res_vld) begin
            r_q0 <= r_q1;
        end else if (w_pop && w_res_vld) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= w_res;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= w_res;
            end
        end else begin
            r_q0 <= r_q0;
        end
    end

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_sample_out = r_q0;

    a_inflight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight != 2'd3)
        else $error("more than two sample requests in flight");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_vld && r_cnt == 2'd2) |-> w_pop)
        else $error("result pushed into a full output queue");

    a_queue_le_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_inflight)
        else $error("more queued results than requests in flight");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 2'd2) |-> !w_take)
        else $error("sample request taken with no result slot");

endmodule

/* test/tb_wavetable_morph_interpolator.sv */
// ============================================================================
// tb_wavetable_morph_interpolator
// Self-checking bench for the wavetable morph interpolator. Bank writes and
// sample requests go through the input channel with random gaps; a local
// model of the bank and the 1D/2D crossfade predicts each sample, and every
// returned sample is checked in order against it. A sample request is only
// sent once every bank entry it reads has been loaded.
// ============================================================================
`timescale 1ns / 1ps

module tb_wavetable_morph_interpolator;
    import wmi_pkg::*;

    localparam logic       FUNC_WRITE    = 1'b0;
    localparam logic       FUNC_SAMPLE   = 1'b1;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 32;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SEGMENT_ITEMS = 32;
    localparam int         SEGMENT_COUNT = 9;

    typedef enum {FILL_RANDOM, FILL_TOP, FILL_BOTTOM} t_fill;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       func = FUNC_WRITE;
    logic [STORE_ADDR_W-1:0]    bank_address = '0;
    logic signed [SAMPLE_W-1:0] bank_data = '0;
    logic [31:0]                phase = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index = '0;
    logic [15:0]                cfg_data = '0;

    logic signed [SAMPLE_W-1:0] wave_image [STORE_DEPTH];
    bit                         loaded [STORE_DEPTH];
    logic [STORE_ADDR_W-1:0]    read_list [8];
    logic                       cfg_two_d = 1'b0;
    logic [15:0]                cfg_morph_x = '0;
    logic [15:0]                cfg_morph_y = '0;

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int                         mismatches = 0;
    int                         cycle_count = 0;
    bit                         steady = 1'b0;

    wavetable_morph_interpolator dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (func),
        .i_bank_address (bank_address),
        .i_bank_data    (bank_data),
        .i_phase        (phase),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_sample_out   (sample_out),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= 35);
    end

    function automatic void morph_origin(output logic [WAVE_NUM_BITS-1:0] w,
                                         output logic [FRAC_W-1:0] bx,
                                         output logic [FRAC_W-1:0] cy);
        logic [31:0] sx;
        logic [31:0] sy;
        if (!cfg_two_d) begin
            sx = (32'(cfg_morph_x) * 32'(SCALE_1D)) >> 8;
            w  = sx[21:16];
            bx = sx[15:0];
            cy = '0;
        end else begin
            sx = (32'(cfg_morph_x) * 32'(SCALE_2D)) >> 8;
            sy = (32'(cfg_morph_y) * 32'(SCALE_2D)) >> 8;
            w  = {sy[18:16], sx[18:16]};
            bx = sx[15:0];
            cy = sy[15:0];
        end
    endfunction

    function automatic longint interp_wave(logic [WAVE_NUM_BITS-1:0] w, logic [31:0] ph);
        logic [WAVE_ADDR_BITS-1:0] i0;
        logic [WAVE_ADDR_BITS-1:0] i1;
        longint f;
        longint s0;
        longint s1;
        i0 = ph[31:24];
        i1 = i0 + 1'b1;
        f  = ph[23:8];
        s0 = wave_image[{w, i0}];
        s1 = wave_image[{w, i1}];
        return s0 * (longint'(FRAC_MAX) - f) + s1 * f;
    endfunction

    function automatic longint crossfade(logic [WAVE_NUM_BITS-1:0] w, logic [FRAC_W-1:0] bx,
                                         logic [31:0] ph);
        longint va;
        longint vb;
        longint bl;
        va = interp_wave(w, ph);
        vb = interp_wave(w + 1'b1, ph);
        bl = bx;
        return (va * (longint'(FRAC_MAX) - bl) + vb * bl) >>> 32;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] morphed_sample(logic [31:0] ph);
        logic [WAVE_NUM_BITS-1:0] w;
        logic [FRAC_W-1:0]        bx;
        logic [FRAC_W-1:0]        cy;
        longint                   r;
        longint                   row0;
        longint                   row1;
        longint                   cl;
        morph_origin(w, bx, cy);
        if (!cfg_two_d) begin
            r = crossfade(w, bx, ph);
        end else begin
            row0 = crossfade(w, bx, ph);
            row1 = crossfade(w + 6'd8, bx, ph);
            cl   = cy;
            r    = (row0 * (longint'(FRAC_MAX) - cl) + row1 * cl) >>> 16;
        end
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return SAMPLE_W'(r);
    endfunction

    function automatic int list_reads(logic [31:0] ph);
        logic [WAVE_NUM_BITS-1:0]  w;
        logic [FRAC_W-1:0]         bx;
        logic [FRAC_W-1:0]         cy;
        logic [WAVE_NUM_BITS-1:0]  waves [4];
        logic [WAVE_ADDR_BITS-1:0] i0;
        int                        n;
        morph_origin(w, bx, cy);
        waves[0] = w;
        waves[1] = w + 6'd1;
        waves[2] = w + 6'd8;
        waves[3] = w + 6'd9;
        i0 = ph[31:24];
        n  = cfg_two_d ? 4 : 2;
        for (int j = 0; j < n; j++) begin
            read_list[2*j]   = {waves[j], i0};
            read_list[2*j+1] = {waves[j], i0 + 8'd1};
        end
        return 2 * n;
    endfunction

    always @(posedge clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("sample %0d returned with no request pending", sample_out);
                end
            end else begin
                want = expected_samples.pop_front();
                if (sample_out !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("sample mismatch: expected %0d, got %0d", want, sample_out);
                    end
                end
            end
        end
    end

    task automatic send_item(logic f, logic [STORE_ADDR_W-1:0] addr,
                             logic signed [SAMPLE_W-1:0] data, logic [31:0] ph);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 35) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        func         = f;
        bank_address = addr;
        bank_data    = data;
        phase        = ph;
        do @(posedge clk); while (!in_ready);
        if (f == FUNC_WRITE) begin
            wave_image[addr] = data;
            loaded[addr]     = 1'b1;
        end else begin
            expected_samples.push_back(morphed_sample(ph));
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(logic [1:0] index, logic [15:0] data);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_TWO_D:   cfg_two_d   = data[0];
            CFG_MORPH_X: cfg_morph_x = data;
            CFG_MORPH_Y: cfg_morph_y = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic prime_reads(logic [31:0] ph, t_fill fill);
        int                         n;
        logic signed [SAMPLE_W-1:0] value;
        n = list_reads(ph);
        for (int k = 0; k < n; k++) begin
            case (fill)
                FILL_TOP:    value = 16'sh7FFF;
                FILL_BOTTOM: value = -16'sh8000;
                default:     value = SAMPLE_W'($urandom);
            endcase
            if (fill != FILL_RANDOM || !loaded[read_list[k]]) begin
                send_item(FUNC_WRITE, read_list[k], value, $urandom);
            end
        end
    endtask

    task automatic request_sample(logic [31:0] ph);
        prime_reads(ph, FILL_RANDOM);
        send_item(FUNC_SAMPLE, STORE_ADDR_W'($urandom), SAMPLE_W'($urandom), ph);
    endtask

    function automatic logic [15:0] pick_morph();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_phase();
        logic [31:0] ph;
        ph = $urandom;
        case ($urandom_range(0, 7))
            0:       ph[23:8] = 16'h0000;
            1:       ph[23:8] = FRAC_MAX;
            2:       ph[31:24] = 8'hFF;
            default: ;
        endcase
        return ph;
    endfunction

    task automatic run_segment(int count);
        set_register(CFG_TWO_D, 16'($urandom));
        set_register(CFG_MORPH_X, pick_morph());
        set_register(CFG_MORPH_Y, pick_morph());
        if ($urandom_range(0, 3) == 0) begin
            set_register(CFG_UNUSED, 16'($urandom));
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 70) begin
                request_sample(pick_phase());
            end else begin
                send_item(FUNC_WRITE, STORE_ADDR_W'($urandom), SAMPLE_W'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_reset_defaults();
        prime_reads(32'hFFFF_FFFF, FILL_TOP);
        send_item(FUNC_SAMPLE, '1, '1, 32'hFFFF_FFFF);
        prime_reads(32'hFFFF_FFFF, FILL_BOTTOM);
        send_item(FUNC_SAMPLE, '0, '0, 32'hFF00_0000);
        send_item(FUNC_SAMPLE, '1, -16'sh8000, 32'hFFFF_FFFF);
    endtask

    task automatic test_register_index();
        set_register(CFG_UNUSED, 16'hFFFF);
        request_sample(32'hFF80_0000);
    endtask

    task automatic test_edge_values();
        set_register(CFG_MORPH_X, 16'hFFFF);
        set_register(CFG_TWO_D, 16'h0001);
        set_register(CFG_MORPH_Y, 16'hFFFF);
        prime_reads(32'h7FFF_FF00, FILL_BOTTOM);
        send_item(FUNC_SAMPLE, '0, 16'sh7FFF, 32'h7FFF_FF00);
        send_item(FUNC_SAMPLE, '1, '0, 32'h7F00_00FF);
    endtask

    task automatic test_random_morph();
        for (int s = 0; s < SEGMENT_COUNT; s++) begin
            run_segment(SEGMENT_ITEMS);
        end
    endtask

    task automatic test_steady_stream();
        settle();
        steady = 1'b1;
        run_segment(SEGMENT_ITEMS);
        settle();
        steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_index();
        test_edge_values();
        test_random_morph();
        test_steady_stream();

        settle();
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/wmi_pkg.sv
rtl/wmi_ram.sv
rtl/wmi_seq.sv
rtl/wmi_mix.sv
rtl/wavetable_morph_interpolator.sv
test/tb_wavetable_morph_interpolator.sv
